// ----- hw/rtl/bcs_pkg.sv -----
// Shared constants and types for the barycentric color sampler.
`timescale 1ns / 1ps
package bcs_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int VTX_BITS       = 63;
  localparam int COLOR_BITS     = 24;
  localparam int CHAN_BITS      = 8;
  localparam int NUM_CHAN       = 3;
  localparam int NUM_AXIS       = 3;
  localparam int LIMIT_BITS     = 32;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 32'd43;

  typedef logic [CHAN_BITS-1:0] chan_t;

  // Control that travels with each beat through the divider stages.
  typedef struct packed {
    logic valid;
    logic ok;
  } bcs_ctl_t;

endpackage

// ----- hw/rtl/bcs_ifs.sv -----
// Channel interfaces for the barycentric color sampler.
`timescale 1ns / 1ps
interface bcs_in_if import bcs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [VTX_BITS-1:0]   vertex_a;
  logic [VTX_BITS-1:0]   vertex_b;
  logic [VTX_BITS-1:0]   vertex_c;
  logic [COLOR_BITS-1:0] color_a;
  logic [COLOR_BITS-1:0] color_b;
  logic [COLOR_BITS-1:0] color_c;
  logic [VTX_BITS-1:0]   query_point;
  modport source (output valid, vertex_a, vertex_b, vertex_c, color_a, color_b, color_c,
                  query_point, input ready);
  modport sink (input valid, vertex_a, vertex_b, vertex_c, color_a, color_b, color_c,
                query_point, output ready);
endinterface

interface bcs_out_if import bcs_pkg::*;;
  logic  valid;
  logic  ready;
  logic  sample_ok;
  chan_t red;
  chan_t green;
  chan_t blue;
  modport source (output valid, sample_ok, red, green, blue, input ready);
  modport sink (input valid, sample_ok, red, green, blue, output ready);
endinterface

interface bcs_cfg_if import bcs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [LIMIT_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/bcs_div_step.sv -----
// One restoring division step, producing one quotient bit per color channel.
`timescale 1ns / 1ps
module bcs_div_step import bcs_pkg::*; #(
  parameter int SW  = 102,
  parameter int LW  = 91,
  parameter int BIT = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bcs_ctl_t             ctl_in,
  input  logic [LW-1:0]        len_in,
  input  logic signed [SW-1:0] rem_in [NUM_CHAN],
  input  chan_t                q_in [NUM_CHAN],
  output bcs_ctl_t             ctl,
  output logic [LW-1:0]        len,
  output logic signed [SW-1:0] rem [NUM_CHAN],
  output chan_t                q [NUM_CHAN]
);

  logic signed [SW-1:0] trial;
  logic signed [SW-1:0] rem_next [NUM_CHAN];
  chan_t                q_next [NUM_CHAN];

  always_comb begin
    trial = $signed({{(SW-LW){1'b0}}, len_in}) <<< BIT;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (trial <= rem_in[c]) begin
        rem_next[c] = rem_in[c] - trial;
        q_next[c]   = q_in[c] | (chan_t'(1) << BIT);
      end else begin
        rem_next[c] = rem_in[c];
        q_next[c]   = q_in[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len <= len_in;
      for (int c = 0; c < NUM_CHAN; c++) begin
        rem[c] <= rem_next[c];
        q[c]   <= q_next[c];
      end
    end
  end

endmodule

// ----- hw/rtl/barycentric_color_sample.sv -----
// Top level of the pipelined barycentric color sampler.
`timescale 1ns / 1ps
//
//  Channel     Dir   Beat carries
//  samp_in     in    three vertices, three RGB colors, query point
//  samp_out    out   sample_ok, red, green, blue
//  cfg         in    degenerate_limit write data
//
// One beat enters per cycle unless samp_out stalls; the pipeline has seven
// arithmetic stages (differences, cross products in two steps, dot products
// split into half-width partial products, channel sums) and eight restoring
// division stages, one quotient bit each. The last division stage is the
// output register. A stall on samp_out freezes the whole pipeline, so no beat
// is lost or repeated. Reset clears the stage valid bits and loads the
// degenerate limit with its default; no clearing pass is needed.
module barycentric_color_sample import bcs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  bcs_in_if.sink    samp_in,
  bcs_out_if.source samp_out,
  bcs_cfg_if.sink   cfg
);

  // Widths of the arithmetic, all following from the coordinate and channel widths.
  // The fraction bits cancel in the final ratio, so they play no part here.
  localparam int DW  = COORD_BITS + 1;   // coordinate difference
  localparam int PW  = 2 * DW;           // product of two differences
  localparam int NW  = PW + 1;           // cross product component
  localparam int LO  = (NW + 1) / 2;     // low split of a multiplier operand
  localparam int HI  = NW - LO;          // high split
  localparam int QW  = 2 * NW;           // full product of two components
  localparam int DTW = QW + 2;           // three-term dot product
  localparam int LW  = DTW - 1;          // positive squared length
  localparam int SW  = DTW + CHAN_BITS + 2;  // color-weighted sum
  localparam int NSTEP = CHAN_BITS;

  logic en;
  logic [LIMIT_BITS-1:0] degenerate_limit;

  // Configuration register; writes are always taken.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      degenerate_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      degenerate_limit <= cfg.data;
    end
  end

  // Stage valid bits for the arithmetic stages.
  logic [7:1] vld;
  bcs_ctl_t   div_ctl [NSTEP+1];

  // The whole pipeline moves unless a finished result is being held.
  assign en            = !div_ctl[NSTEP].valid || samp_out.ready;
  assign samp_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], samp_in.valid};
    end
  end

  // Colors ride along the first six stages.
  logic [3*COLOR_BITS-1:0] col [1:6];
  always_ff @(posedge clk) begin
    if (en) begin
      col[1] <= {samp_in.color_c, samp_in.color_b, samp_in.color_a};
      for (int s = 2; s <= 6; s++) col[s] <= col[s-1];
    end
  end

  // Stage 1: unpack coordinates and form the edge and query differences.
  logic signed [DW-1:0] pa [NUM_AXIS], pb [NUM_AXIS], pc [NUM_AXIS], pq [NUM_AXIS];
  // Cross product pairs: 0 normal, 1..3 the sub-triangles opposite A, B, C.
  logic signed [DW-1:0] u1 [4][NUM_AXIS];
  logic signed [DW-1:0] v1 [4][NUM_AXIS];

  always_comb begin
    for (int k = 0; k < NUM_AXIS; k++) begin
      pa[k] = $signed({samp_in.vertex_a[k*COORD_BITS+COORD_BITS-1],
                       samp_in.vertex_a[k*COORD_BITS +: COORD_BITS]});
      pb[k] = $signed({samp_in.vertex_b[k*COORD_BITS+COORD_BITS-1],
                       samp_in.vertex_b[k*COORD_BITS +: COORD_BITS]});
      pc[k] = $signed({samp_in.vertex_c[k*COORD_BITS+COORD_BITS-1],
                       samp_in.vertex_c[k*COORD_BITS +: COORD_BITS]});
      pq[k] = $signed({samp_in.query_point[k*COORD_BITS+COORD_BITS-1],
                       samp_in.query_point[k*COORD_BITS +: COORD_BITS]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXIS; k++) begin
        u1[0][k] <= pb[k] - pa[k];
        v1[0][k] <= pc[k] - pa[k];
        u1[1][k] <= pc[k] - pb[k];
        v1[1][k] <= pq[k] - pb[k];
        u1[2][k] <= pa[k] - pc[k];
        v1[2][k] <= pq[k] - pc[k];
        u1[3][k] <= pb[k] - pa[k];
        v1[3][k] <= pq[k] - pa[k];
      end
    end
  end

  // Stage 2: the two products of each cross product component.
  logic signed [PW-1:0] xp [4][NUM_AXIS][2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < NUM_AXIS; k++) begin
          xp[j][k][0] <= u1[j][(k+1)%3] * v1[j][(k+2)%3];
          xp[j][k][1] <= u1[j][(k+2)%3] * v1[j][(k+1)%3];
        end
      end
    end
  end

  // Stage 3: cross product components.
  logic signed [NW-1:0] w3 [4][NUM_AXIS];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < NUM_AXIS; k++) begin
          w3[j][k] <= NW'(xp[j][k][0]) - NW'(xp[j][k][1]);
        end
      end
    end
  end

  // Stage 4: every vector dotted with the normal, each product split into a
  // signed high half and an unsigned low half of the left operand.
  logic signed [HI+NW-1:0]   ph [4][NUM_AXIS];
  logic signed [LO+NW:0]     pl [4][NUM_AXIS];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < NUM_AXIS; k++) begin
          ph[j][k] <= $signed(w3[j][k][NW-1:LO]) * w3[0][k];
          pl[j][k] <= $signed({1'b0, w3[j][k][LO-1:0]}) * w3[0][k];
        end
      end
    end
  end

  // Stage 5: recombine the partial products.
  logic signed [QW-1:0] pr [4][NUM_AXIS];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < NUM_AXIS; k++) begin
          pr[j][k] <= $signed({ph[j][k], {LO{1'b0}}})
                    + $signed({{(QW-LO-NW-1){pl[j][k][LO+NW]}}, pl[j][k]});
        end
      end
    end
  end

  // Stage 6: dot products and the degenerate test on the squared length.
  logic signed [DTW-1:0] dt [4];
  logic signed [DTW-1:0] dot_sum [4];
  logic                  ok6;
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dot_sum[j] = DTW'(pr[j][0]) + DTW'(pr[j][1]) + DTW'(pr[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) dt[j] <= dot_sum[j];
      ok6 <= dot_sum[0] > $signed({{(DTW-LIMIT_BITS){1'b0}}, degenerate_limit});
    end
  end

  // Stage 7: color-weighted numerators per channel.
  logic signed [SW-1:0] num7 [NUM_CHAN];
  logic [LW-1:0]        len7;
  logic                 ok7;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        num7[c] <= SW'(dt[1]) * $signed({1'b0, col[6][c*CHAN_BITS +: CHAN_BITS]})
                 + SW'(dt[2]) * $signed({1'b0, col[6][COLOR_BITS + c*CHAN_BITS +: CHAN_BITS]})
                 + SW'(dt[3]) * $signed({1'b0,
                                 col[6][2*COLOR_BITS + c*CHAN_BITS +: CHAN_BITS]});
      end
      len7 <= dt[0][LW-1:0];
      ok7  <= ok6;
    end
  end

  // Stages 8 to 15: restoring division, most significant quotient bit first.
  // A non-positive numerator never passes a trial and yields zero, and a
  // quotient of 256 or more saturates at 255 on its own.
  logic [LW-1:0]        div_len [NSTEP+1];
  logic signed [SW-1:0] div_rem [NSTEP+1][NUM_CHAN];
  chan_t                div_q   [NSTEP+1][NUM_CHAN];

  assign div_ctl[0] = '{valid: vld[7], ok: ok7};
  assign div_len[0] = len7;
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      div_rem[0][c] = num7[c];
      div_q[0][c]   = '0;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_div
    bcs_div_step #(
      .SW  (SW),
      .LW  (LW),
      .BIT (NSTEP - 1 - i)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_in (div_ctl[i]),
      .len_in (div_len[i]),
      .rem_in (div_rem[i]),
      .q_in   (div_q[i]),
      .ctl    (div_ctl[i+1]),
      .len    (div_len[i+1]),
      .rem    (div_rem[i+1]),
      .q      (div_q[i+1])
    );
  end

  // The last division stage is the output register; a degenerate triangle
  // reports zero color.
  assign samp_out.valid     = div_ctl[NSTEP].valid;
  assign samp_out.sample_ok = div_ctl[NSTEP].ok;
  assign samp_out.red       = div_ctl[NSTEP].ok ? div_q[NSTEP][0] : '0;
  assign samp_out.green     = div_ctl[NSTEP].ok ? div_q[NSTEP][1] : '0;
  assign samp_out.blue      = div_ctl[NSTEP].ok ? div_q[NSTEP][2] : '0;

  // A failed sample must carry no color.
  a_degenerate_black: assert property (@(posedge clk) disable iff (rst)
    samp_out.valid && !samp_out.sample_ok |->
      samp_out.red == '0 && samp_out.green == '0 && samp_out.blue == '0)
    else $error("degenerate sample carries color");

  // An accepted beat occupies the first stage on the next cycle.
  a_entry: assert property (@(posedge clk) disable iff (rst)
    samp_in.valid && samp_in.ready |=> vld[1])
    else $error("accepted beat missing from first stage");

  // While the output is held, the pipeline does not take new beats.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    samp_out.valid && !samp_out.ready |-> !samp_in.ready)
    else $error("input taken during output stall");

  // A stall keeps the arithmetic stage valid bits unchanged.
  a_stall_keep: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valid bits moved during stall");

endmodule
